/* src/fcfs_scheduler_with_io_bursts_defines.svh */
// ----------------------------------------------------------------------------
// Scheduler assertion macros
// Concurrent assertion wrappers, emptied when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef FCFS_SCHEDULER_WITH_IO_BURSTS_DEFINES_SVH
`define FCFS_SCHEDULER_WITH_IO_BURSTS_DEFINES_SVH

`ifndef SYNTH
// Same-cycle implication.
`define FCFS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scheduler assertion failed");
// Next-cycle implication.
`define FCFS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scheduler assertion failed");
`else
`define FCFS_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define FCFS_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

/* src/fcfs_pkg.sv */
// ----------------------------------------------------------------------------
// Scheduler package
// Shared types, codes and sizes of the FCFS scheduler.
// ----------------------------------------------------------------------------
package fcfs_pkg;

    localparam int MAX_PROCS     = 16;
    localparam int MAX_BURSTS    = 32;
    localparam int TIME_BITS     = 24;
    localparam int PROC_BITS     = 4;
    localparam int SLOT_BITS     = 5;
    localparam int CNT_BITS      = 5;
    localparam int ENTRY_BITS    = TIME_BITS + 1;
    localparam int ADDR_BITS     = PROC_BITS + SLOT_BITS;
    localparam int APB_ADDR_BITS = 3;

    localparam logic [1:0] ACT_LOAD_ARRIVAL = 2'd0;
    localparam logic [1:0] ACT_LOAD_BURST   = 2'd1;
    localparam logic [1:0] ACT_START        = 2'd2;
    localparam logic [1:0] ACT_TICK         = 2'd3;

    localparam logic REG_PROCESS_COUNT = 1'b0;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } alu_op_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOAD,
        S_START,
        S_TICK,
        S_RD0,
        S_RD1,
        S_RD2,
        S_POP,
        S_HMOD,
        S_TINC,
        S_SCAN,
        S_TMOD,
        S_OUT
    } state_t;

    typedef struct packed {
        logic [1:0]           action;
        logic [PROC_BITS-1:0] proc_index;
        logic [SLOT_BITS-1:0] burst_slot;
        logic [TIME_BITS-1:0] load_value;
        logic                 list_end;
    } item_t;

    typedef struct packed {
        logic [TIME_BITS-1:0] time_stamp;
        logic                 cpu_idle;
        logic [PROC_BITS-1:0] ran_process;
        logic                 process_finished;
        logic [TIME_BITS-1:0] finish_time;
        logic [CNT_BITS-1:0]  done_count;
        logic                 all_done;
    } result_t;

    typedef struct packed {
        logic                  en;
        logic [ADDR_BITS-1:0]  addr;
        logic [ENTRY_BITS-1:0] data;
    } mem_wr_t;

endpackage

/* src/fcfs_alu.sv */
// ----------------------------------------------------------------------------
// Shared arithmetic unit
// One adder/subtractor with equality and less-than flags, time-shared by
// the sequencer.
// ----------------------------------------------------------------------------
module fcfs_alu
    import fcfs_pkg::*;
(
    input  alu_op_t              op,
    input  logic [TIME_BITS-1:0] a,
    input  logic [TIME_BITS-1:0] b,
    output logic [TIME_BITS-1:0] res,
    output logic                 eq,
    output logic                 lt
);

    always_comb
    begin
        unique case (op)
            ALU_ADD: res = a + b;
            ALU_SUB: res = a - b;
        endcase
        eq = (a == b);
        lt = (a < b);
    end

endmodule

/* src/fcfs_burst_mem.sv */
// ----------------------------------------------------------------------------
// Burst table memory
// One write port and one registered read port; entries hold an end mark
// above the burst length.
// ----------------------------------------------------------------------------
module fcfs_burst_mem
    import fcfs_pkg::*;
(
    input  logic                  clk,
    input  mem_wr_t               wr,
    input  logic [ADDR_BITS-1:0]  raddr,
    output logic [ENTRY_BITS-1:0] rdata
);

    logic [ENTRY_BITS-1:0] mem [0:MAX_PROCS*MAX_BURSTS-1];
    logic [ENTRY_BITS-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* src/fcfs_scheduler_with_io_bursts.sv */
// A load writes arrival or burst data; a start clears queue and time, then scans; a tick with
// a queued process reads its burst; if that ends, it reads the next entries (S_RD1, S_RD2)
// and pops the head, wrapped by repeated subtraction (S_HMOD). Each tick then advances time
// and scans cap ready times, one per cycle on the one ALU but paused while a queued arrival
// wraps the tail (S_TMOD). One item at a time; busy drops after the one-cycle result strobe,
// which the receiver cannot stall. Reset clears queue, time and flags; process_count is 1.
// ----------------------------------------------------------------------------
// FCFS scheduler with I/O bursts
// Sequencer, queue and process state around a shared ALU and the burst table.
// ----------------------------------------------------------------------------
`include "fcfs_scheduler_with_io_bursts_defines.svh"

module fcfs_scheduler_with_io_bursts
    import fcfs_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  item_t                    item,
    output logic                     strobe,
    output result_t                  result,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_BITS-1:0] paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);

    state_t               state_reg, state_next;
    item_t                item_reg, item_next;
    logic [TIME_BITS-1:0] stamp_reg, stamp_next;
    logic                 idle_reg, idle_next;
    logic [PROC_BITS-1:0] ran_reg, ran_next;
    logic                 fin_reg, fin_next;
    logic [TIME_BITS-1:0] ftime_reg, ftime_next;
    logic [CNT_BITS-1:0]  ft_reg, ft_next;
    logic [TIME_BITS-1:0] tick_reg, tick_next;
    logic [PROC_BITS-1:0] head_reg, head_next;
    logic [PROC_BITS-1:0] tail_reg, tail_next;
    logic [CNT_BITS-1:0]  count_reg, count_next;
    logic [PROC_BITS-1:0] p_reg, p_next;
    logic [SLOT_BITS-1:0] pos_reg, pos_next;
    logic                 ends_reg, ends_next;
    logic                 done_reg, done_next;
    logic [TIME_BITS-1:0] io_reg, io_next;
    logic [CNT_BITS-1:0]  idx_reg, idx_next;
    logic [CNT_BITS-1:0]  modv_reg, modv_next;
    logic [CNT_BITS-1:0]  pc_reg;

    logic [TIME_BITS-1:0] rt_reg   [0:MAX_PROCS-1];
    logic [MAX_PROCS-1:0] pend_reg;
    logic [SLOT_BITS-1:0] bpos_reg [0:MAX_PROCS-1];
    logic [PROC_BITS-1:0] ring_reg [0:MAX_PROCS-1];

    logic                 rt_we;
    logic [PROC_BITS-1:0] rt_widx;
    logic [TIME_BITS-1:0] rt_wdata;
    logic                 pend_we;
    logic [PROC_BITS-1:0] pend_widx;
    logic                 pend_wval;
    logic                 bpos_we;
    logic [PROC_BITS-1:0] bpos_widx;
    logic [SLOT_BITS-1:0] bpos_wval;
    logic                 ring_we;

    alu_op_t              alu_op;
    logic [TIME_BITS-1:0] alu_a, alu_b, alu_res;
    logic                 alu_eq, alu_lt;

    mem_wr_t               mem_wr;
    logic [ADDR_BITS-1:0]  mem_raddr;
    logic [ENTRY_BITS-1:0] mem_rdata;

    logic [CNT_BITS-1:0]  cap;
    logic [PROC_BITS-1:0] p_now;
    logic [SLOT_BITS-1:0] pos_now;
    logic [PROC_BITS-1:0] scan_i;
    logic [TIME_BITS-1:0] burst_val;
    logic                 cfg_wr;

    fcfs_alu u_alu (
        .op  (alu_op),
        .a   (alu_a),
        .b   (alu_b),
        .res (alu_res),
        .eq  (alu_eq),
        .lt  (alu_lt)
    );

    fcfs_burst_mem u_mem (
        .clk   (clk),
        .wr    (mem_wr),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Capacity is process_count clamped to the supported range.
    always_comb
    begin
        if (pc_reg == '0)
        begin
            cap = CNT_BITS'(1);
        end
        else if (pc_reg > CNT_BITS'(MAX_PROCS))
        begin
            cap = CNT_BITS'(MAX_PROCS);
        end
        else
        begin
            cap = pc_reg;
        end
    end

    assign p_now     = ring_reg[head_reg];
    assign pos_now   = bpos_reg[p_now];
    assign scan_i    = idx_reg[PROC_BITS-1:0];
    assign burst_val = mem_rdata[TIME_BITS-1:0];

    // Configuration port.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == REG_PROCESS_COUNT) ? {{(32-CNT_BITS){1'b0}}, pc_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= CNT_BITS'(1);
        end
        else if (cfg_wr && (paddr[2] == REG_PROCESS_COUNT))
        begin
            pc_reg <= pwdata[CNT_BITS-1:0];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        item_next  = item_reg;
        stamp_next = stamp_reg;
        idle_next  = idle_reg;
        ran_next   = ran_reg;
        fin_next   = fin_reg;
        ftime_next = ftime_reg;
        ft_next    = ft_reg;
        tick_next  = tick_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        p_next     = p_reg;
        pos_next   = pos_reg;
        ends_next  = ends_reg;
        done_next  = done_reg;
        io_next    = io_reg;
        idx_next   = idx_reg;
        modv_next  = modv_reg;

        rt_we     = 1'b0;
        rt_widx   = p_reg;
        rt_wdata  = alu_res;
        pend_we   = 1'b0;
        pend_widx = p_reg;
        pend_wval = 1'b0;
        bpos_we   = 1'b0;
        bpos_widx = p_reg;
        bpos_wval = '0;
        ring_we   = 1'b0;

        mem_wr.en   = 1'b0;
        mem_wr.addr = {p_reg, pos_reg};
        mem_wr.data = '0;
        mem_raddr   = {p_reg, pos_reg};

        alu_op = ALU_ADD;
        alu_a  = tick_reg;
        alu_b  = TIME_BITS'(1);

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    item_next  = item;
                    stamp_next = tick_reg;
                    idle_next  = 1'b0;
                    ran_next   = '0;
                    fin_next   = 1'b0;
                    ftime_next = '0;
                    unique case (item.action)
                        ACT_LOAD_ARRIVAL: state_next = S_LOAD;
                        ACT_LOAD_BURST:   state_next = S_LOAD;
                        ACT_START:        state_next = S_START;
                        ACT_TICK:         state_next = S_TICK;
                    endcase
                end
            end
            S_LOAD:
            begin
                if (item_reg.action == ACT_LOAD_ARRIVAL)
                begin
                    rt_we     = 1'b1;
                    rt_widx   = item_reg.proc_index;
                    rt_wdata  = item_reg.load_value;
                    pend_we   = 1'b1;
                    pend_widx = item_reg.proc_index;
                    pend_wval = 1'b1;
                    bpos_we   = 1'b1;
                    bpos_widx = item_reg.proc_index;
                    bpos_wval = '0;
                end
                else
                begin
                    mem_wr.en   = 1'b1;
                    mem_wr.addr = {item_reg.proc_index, item_reg.burst_slot};
                    mem_wr.data = {item_reg.list_end, item_reg.load_value};
                end
                state_next = S_OUT;
            end
            S_START:
            begin
                head_next  = '0;
                tail_next  = '0;
                count_next = '0;
                tick_next  = '0;
                ft_next    = '0;
                stamp_next = '0;
                idx_next   = '0;
                state_next = S_SCAN;
            end
            S_TICK:
            begin
                if (count_reg == '0)
                begin
                    idle_next  = 1'b1;
                    state_next = S_TINC;
                end
                else
                begin
                    p_next     = p_now;
                    pos_next   = pos_now;
                    ran_next   = p_now;
                    mem_raddr  = {p_now, pos_now};
                    state_next = S_RD0;
                end
            end
            S_RD0:
            begin
                if (mem_rdata[TIME_BITS])
                begin
                    // An end mark at the current slot completes the process now.
                    ends_next  = 1'b1;
                    done_next  = 1'b1;
                    state_next = S_POP;
                end
                else
                begin
                    alu_op      = ALU_SUB;
                    alu_a       = burst_val;
                    alu_b       = TIME_BITS'(1);
                    ends_next   = (burst_val[TIME_BITS-1:1] == '0);
                    done_next   = 1'b0;
                    mem_wr.en   = 1'b1;
                    mem_wr.data = (burst_val[TIME_BITS-1:1] == '0) ? '0 : {1'b0, alu_res};
                    if (burst_val[TIME_BITS-1:1] != '0)
                    begin
                        state_next = S_TINC;
                    end
                    else if (pos_reg == SLOT_BITS'(MAX_BURSTS - 1))
                    begin
                        done_next  = 1'b1;
                        state_next = S_POP;
                    end
                    else
                    begin
                        mem_raddr  = {p_reg, pos_reg + SLOT_BITS'(1)};
                        state_next = S_RD1;
                    end
                end
            end
            S_RD1:
            begin
                io_next = burst_val;
                if (mem_rdata[TIME_BITS] || (pos_reg == SLOT_BITS'(MAX_BURSTS - 2)))
                begin
                    done_next  = 1'b1;
                    state_next = S_POP;
                end
                else
                begin
                    mem_raddr  = {p_reg, pos_reg + SLOT_BITS'(2)};
                    state_next = S_RD2;
                end
            end
            S_RD2:
            begin
                done_next  = mem_rdata[TIME_BITS];
                state_next = S_POP;
            end
            S_POP:
            begin
                modv_next  = {1'b0, head_reg} + CNT_BITS'(1);
                count_next = count_reg - CNT_BITS'(1);
                if (done_reg)
                begin
                    if (ft_reg != '1)
                    begin
                        ft_next = ft_reg + CNT_BITS'(1);
                    end
                    pend_we    = 1'b1;
                    pend_wval  = 1'b0;
                    fin_next   = 1'b1;
                    ftime_next = stamp_reg;
                end
                else
                begin
                    // A zero-length I/O burst still costs one tick.
                    alu_a     = stamp_reg;
                    alu_b     = (io_reg == '0) ? TIME_BITS'(1) : io_reg;
                    rt_we     = 1'b1;
                    rt_wdata  = alu_res;
                    pend_we   = 1'b1;
                    pend_wval = 1'b1;
                    bpos_we   = 1'b1;
                    bpos_wval = pos_reg + SLOT_BITS'(2);
                end
                state_next = S_HMOD;
            end
            S_HMOD:
            begin
                alu_op = ALU_SUB;
                alu_a  = TIME_BITS'(modv_reg);
                alu_b  = TIME_BITS'(cap);
                if (alu_lt)
                begin
                    head_next  = modv_reg[PROC_BITS-1:0];
                    state_next = S_TINC;
                end
                else
                begin
                    modv_next = alu_res[CNT_BITS-1:0];
                end
            end
            S_TINC:
            begin
                tick_next  = alu_res;
                idx_next   = '0;
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                alu_a = rt_reg[scan_i];
                alu_b = tick_reg;
                if (idx_reg == cap)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    idx_next = idx_reg + CNT_BITS'(1);
                    if (pend_reg[scan_i] && alu_eq && (count_reg < cap))
                    begin
                        ring_we    = 1'b1;
                        count_next = count_reg + CNT_BITS'(1);
                        pend_we    = 1'b1;
                        pend_widx  = scan_i;
                        pend_wval  = 1'b0;
                        modv_next  = {1'b0, tail_reg} + CNT_BITS'(1);
                        state_next = S_TMOD;
                    end
                end
            end
            S_TMOD:
            begin
                alu_op = ALU_SUB;
                alu_a  = TIME_BITS'(modv_reg);
                alu_b  = TIME_BITS'(cap);
                if (alu_lt)
                begin
                    tail_next  = modv_reg[PROC_BITS-1:0];
                    state_next = S_SCAN;
                end
                else
                begin
                    modv_next = alu_res[CNT_BITS-1:0];
                end
            end
            S_OUT:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ft_reg    <= '0;
            tick_reg  <= '0;
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
            pend_reg  <= '0;
            for (int i = 0; i < MAX_PROCS; i++)
            begin
                bpos_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            ft_reg    <= ft_next;
            tick_reg  <= tick_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
            if (pend_we)
            begin
                pend_reg[pend_widx] <= pend_wval;
            end
            if (bpos_we)
            begin
                bpos_reg[bpos_widx] <= bpos_wval;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg  <= item_next;
        stamp_reg <= stamp_next;
        idle_reg  <= idle_next;
        ran_reg   <= ran_next;
        fin_reg   <= fin_next;
        ftime_reg <= ftime_next;
        p_reg     <= p_next;
        pos_reg   <= pos_next;
        ends_reg  <= ends_next;
        done_reg  <= done_next;
        io_reg    <= io_next;
        idx_reg   <= idx_next;
        modv_reg  <= modv_next;
        if (rt_we)
        begin
            rt_reg[rt_widx] <= rt_wdata;
        end
        if (ring_we)
        begin
            ring_reg[tail_reg] <= scan_i;
        end
    end

    assign busy   = (state_reg != S_IDLE);
    assign strobe = (state_reg == S_OUT);

    always_comb
    begin
        result.time_stamp       = stamp_reg;
        result.cpu_idle         = idle_reg;
        result.ran_process      = ran_reg;
        result.process_finished = fin_reg;
        result.finish_time      = ftime_reg;
        result.done_count       = ft_reg;
        result.all_done         = (ft_reg >= cap);
    end

    `FCFS_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, count_reg <= CNT_BITS'(MAX_PROCS))
    `FCFS_ASSERT_NXT(a_accept_busy, clk, rst_n, start && !busy, busy)
    `FCFS_ASSERT_NXT(a_strobe_release, clk, rst_n, strobe, !busy && !strobe)
    `FCFS_ASSERT_IMP(a_idle_no_finish, clk, rst_n, strobe && result.cpu_idle, !result.process_finished)
    `FCFS_ASSERT_IMP(a_pop_ends, clk, rst_n, state_reg == S_POP, ends_reg && (count_reg != '0))

endmodule

/* tb/fcfs_scheduler_with_io_bursts_test.sv */
// ----------------------------------------------------------------------------
// FCFS scheduler testbench
// Drives load, start and tick commands with random gaps, writes the process
// count over the APB port between phases, and checks every result beat
// against a cycle-free predictor of the scheduler in the testbench or a hand-written result.
// ----------------------------------------------------------------------------
module fcfs_scheduler_with_io_bursts_test;
    import fcfs_pkg::*;

    logic                     clk;
    logic                     rst_n;
    logic                     start;
    logic                     busy;
    item_t                    item;
    logic                     strobe;
    result_t                  result;
    logic                     psel;
    logic                     penable;
    logic                     pwrite;
    logic [APB_ADDR_BITS-1:0] paddr;
    logic [31:0]              pwdata;
    logic [31:0]              prdata;
    logic                     pready;

    fcfs_scheduler_with_io_bursts i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .item    (item),
        .strobe  (strobe),
        .result  (result),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    typedef struct {
        item_t   cmd;
        bit      typed;
        result_t outcome;
    } script_row_t;

    // Scheduler state as the testbench sees it.
    logic [ENTRY_BITS-1:0] burst_mem [MAX_PROCS*MAX_BURSTS];
    logic [TIME_BITS-1:0]  wake_time [MAX_PROCS];
    bit                    waiting   [MAX_PROCS];
    int                    next_slot [MAX_PROCS];
    int                    run_queue [MAX_PROCS];
    int                    q_head;
    int                    q_tail;
    int                    q_len;
    logic [TIME_BITS-1:0]  now_tick;
    int                    completed;
    int                    proc_limit;

    result_t     due_results [$];
    script_row_t script [$];
    int          mismatches;
    int          random_items;
    bit          calm;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #20000000;
        $display("end of test: mismatches");
        $finish;
    end

    function automatic int queue_cap();
        if (proc_limit < 1)
            return 1;
        if (proc_limit > MAX_PROCS)
            return MAX_PROCS;
        return proc_limit;
    endfunction

    function automatic bit is_list_end(int p, int s);
        if (s >= MAX_BURSTS)
            return 1'b1;
        return burst_mem[p*MAX_BURSTS+s][TIME_BITS];
    endfunction

    function automatic void enqueue(int p);
        int c;
        c = queue_cap();
        if (q_len >= c)
            return;
        run_queue[q_tail % MAX_PROCS] = p;
        q_tail = (q_tail + 1) % c;
        q_len++;
        waiting[p] = 1'b0;
    endfunction

    function automatic void admit_arrivals(logic [TIME_BITS-1:0] t);
        int c;
        c = queue_cap();
        for (int i = 0; i < c; i++)
            if (waiting[i] && wake_time[i] == t && q_len < c)
                enqueue(i);
    endfunction

    function automatic result_t schedule_step(item_t it);
        result_t              r;
        logic [TIME_BITS-1:0] t;
        logic [TIME_BITS-1:0] v;
        logic [TIME_BITS-1:0] io;
        int                   p;
        int                   pos;
        int                   idx;
        bit                   ends;
        bit                   done;
        r = '0;
        r.time_stamp = now_tick;
        case (it.action)
            ACT_LOAD_ARRIVAL:
            begin
                wake_time[it.proc_index] = it.load_value;
                waiting[it.proc_index] = 1'b1;
                next_slot[it.proc_index] = 0;
            end
            ACT_LOAD_BURST:
                burst_mem[it.proc_index*MAX_BURSTS+it.burst_slot] = {it.list_end, it.load_value};
            ACT_START:
            begin
                q_head = 0;
                q_tail = 0;
                q_len = 0;
                now_tick = '0;
                completed = 0;
                r.time_stamp = '0;
                admit_arrivals('0);
            end
            default:
            begin
                t = now_tick;
                if (q_len == 0)
                    r.cpu_idle = 1'b1;
                else
                begin
                    p = run_queue[q_head % MAX_PROCS] % MAX_PROCS;
                    pos = next_slot[p];
                    r.ran_process = PROC_BITS'(p);
                    if (is_list_end(p, pos))
                    begin
                        ends = 1'b1;
                        done = 1'b1;
                    end
                    else
                    begin
                        idx = p*MAX_BURSTS + pos;
                        v = burst_mem[idx][TIME_BITS-1:0];
                        ends = (v <= 1);
                        burst_mem[idx] = ends ? '0 : {1'b0, v - 1'b1};
                        done = is_list_end(p, pos + 1) || is_list_end(p, pos + 2);
                    end
                    if (ends)
                    begin
                        if (q_len != 0)
                        begin
                            q_head = (q_head + 1) % queue_cap();
                            q_len--;
                        end
                        if (done)
                        begin
                            if (completed < 31)
                                completed++;
                            waiting[p] = 1'b0;
                            r.process_finished = 1'b1;
                            r.finish_time = t;
                        end
                        else
                        begin
                            io = burst_mem[p*MAX_BURSTS+pos+1][TIME_BITS-1:0];
                            if (io == 0)
                                io = TIME_BITS'(1);
                            wake_time[p] = t + io;
                            waiting[p] = 1'b1;
                            next_slot[p] = pos + 2;
                        end
                    end
                end
                now_tick = t + 1'b1;
                admit_arrivals(now_tick);
                r.time_stamp = t;
            end
        endcase
        r.done_count = CNT_BITS'(completed);
        r.all_done = (completed >= queue_cap());
        return r;
    endfunction

    task automatic report(string field, logic [31:0] got, logic [31:0] want);
        $display("mismatch at %0t: %s got %0h expected %0h", $realtime, field, got, want);
        mismatches++;
    endtask

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && strobe)
        begin
            if (due_results.size() == 0)
                report("unexpected result beat", 32'(result.time_stamp), 32'd0);
            else
            begin
                want = due_results.pop_front();
                if (result.time_stamp !== want.time_stamp)
                    report("time_stamp", 32'(result.time_stamp), 32'(want.time_stamp));
                if (result.cpu_idle !== want.cpu_idle)
                    report("cpu_idle", 32'(result.cpu_idle), 32'(want.cpu_idle));
                if (result.ran_process !== want.ran_process)
                    report("ran_process", 32'(result.ran_process), 32'(want.ran_process));
                if (result.process_finished !== want.process_finished)
                    report("process_finished", 32'(result.process_finished),
                           32'(want.process_finished));
                if (result.finish_time !== want.finish_time)
                    report("finish_time", 32'(result.finish_time), 32'(want.finish_time));
                if (result.done_count !== want.done_count)
                    report("done_count", 32'(result.done_count), 32'(want.done_count));
                if (result.all_done !== want.all_done)
                    report("all_done", 32'(result.all_done), 32'(want.all_done));
            end
        end
    end

    // Presents one command and waits for it to be taken. The start line is
    // left high after acceptance so that back-to-back commands need no gap.
    task automatic issue(item_t it, bit typed = 1'b0, result_t outcome = '0);
        result_t predicted;
        int gap;
        gap = calm ? 0 : $urandom_range(0, 12);
        @(negedge clk);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start <= 1'b1;
        item <= it;
        do
            @(posedge clk);
        while (busy);
        predicted = schedule_step(it);
        due_results.push_back(typed ? outcome : predicted);
    endtask

    task automatic set_process_count(logic [31:0] value);
        // Drop start while the last command is still busy so it is not taken twice.
        @(negedge clk);
        start <= 1'b0;
        while (due_results.size() != 0)
            @(posedge clk);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= APB_ADDR_BITS'(4 * int'(REG_PROCESS_COUNT));
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        proc_limit = int'(value[CNT_BITS-1:0]);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    function automatic item_t make_item(logic [1:0] act, int p, int s, int v, bit e);
        item_t it;
        it.action = act;
        it.proc_index = PROC_BITS'(p);
        it.burst_slot = SLOT_BITS'(s);
        it.load_value = TIME_BITS'(v);
        it.list_end = e;
        return it;
    endfunction

    function automatic void add_row(item_t it, bit typed = 1'b0, result_t outcome = '0);
        script_row_t row;
        row.cmd = it;
        row.typed = typed;
        row.outcome = outcome;
        script.push_back(row);
    endfunction

    function automatic item_t noise_item();
        item_t it;
        it.action = 2'($urandom_range(0, 3));
        it.proc_index = 4'($urandom);
        it.burst_slot = 5'($urandom);
        it.load_value = 24'($urandom);
        it.list_end = 1'($urandom);
        return it;
    endfunction

    initial
    begin
        result_t r;
        logic [31:0] pc;
        int c;
        int len;
        int ticks;
        start = 1'b0;
        item = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        rst_n = 1'b0;
        mismatches = 0;
        random_items = 0;
        calm = 1'b0;
        q_head = 0;
        q_tail = 0;
        q_len = 0;
        now_tick = '0;
        completed = 0;
        proc_limit = 1;
        for (int i = 0; i < MAX_PROCS*MAX_BURSTS; i++)
            burst_mem[i] = '0;
        for (int i = 0; i < MAX_PROCS; i++)
        begin
            wake_time[i] = '0;
            waiting[i] = 1'b0;
            next_slot[i] = 0;
            run_queue[i] = 0;
        end
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Idle tick straight after reset, then one process that runs a
        // zero-length CPU burst, a zero-length I/O burst and a burst of two.
        r = '0;
        r.cpu_idle = 1'b1;
        add_row(make_item(ACT_TICK, 0, 0, 0, 0), 1'b1, r);
        add_row(make_item(ACT_LOAD_ARRIVAL, 1, 0, 24'hFFFFFF, 1));
        add_row(make_item(ACT_LOAD_BURST, 0, 0, 0, 0));
        add_row(make_item(ACT_LOAD_BURST, 0, 1, 0, 0));
        add_row(make_item(ACT_LOAD_BURST, 0, 2, 2, 0));
        add_row(make_item(ACT_LOAD_BURST, 0, 3, 24'hFFFFFF, 1));
        add_row(make_item(ACT_LOAD_BURST, 15, 31, 24'hFFFFFF, 1));
        add_row(make_item(ACT_LOAD_ARRIVAL, 0, 31, 0, 0));
        add_row(make_item(ACT_START, 15, 31, 24'hFFFFFF, 1), 1'b1, '0);
        add_row(make_item(ACT_TICK, 0, 0, 0, 0));
        add_row(make_item(ACT_TICK, 0, 0, 0, 0));
        r = '0;
        r.time_stamp = 2;
        r.process_finished = 1'b1;
        r.finish_time = 2;
        r.done_count = 1;
        r.all_done = 1'b1;
        add_row(make_item(ACT_TICK, 15, 31, 24'hFFFFFF, 1), 1'b1, r);
        add_row(make_item(ACT_TICK, 0, 0, 0, 0));
        foreach (script[i])
            issue(script[i].cmd, script[i].typed, script[i].outcome);

        // Fill the whole burst table so that no later read hits an unwritten entry.
        for (int p = 0; p < MAX_PROCS; p++)
            for (int s = 0; s < MAX_BURSTS; s++)
            begin
                issue(make_item(ACT_LOAD_BURST, p, s,
                                ($urandom_range(0, 3) != 0) ? $urandom_range(0, 4) : $urandom,
                                ($urandom_range(0, 4) == 0)));
                random_items++;
            end

        while (random_items < 900)
        begin
            case ($urandom_range(0, 5))
                0: pc = 1;
                1: pc = 16;
                2: pc = 0;
                3: pc = 31;
                default: pc = $urandom_range(2, 15);
            endcase
            set_process_count(pc);
            calm = ($urandom_range(0, 3) == 0);
            c = queue_cap();
            // Well-formed burst lists and arrivals for the processes in use.
            for (int p = 0; p < c; p++)
            begin
                len = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 6);
                for (int s = 0; s < len; s++)
                begin
                    issue(make_item(ACT_LOAD_BURST, p, s,
                                    ($urandom_range(0, 40) == 0) ? $urandom_range(5, 40)
                                                                 : $urandom_range(0, 4), 0));
                    random_items++;
                end
                issue(make_item(ACT_LOAD_BURST, p, len, $urandom, 1));
                if ($urandom_range(0, 9) != 0)
                    issue(make_item(ACT_LOAD_ARRIVAL, p, $urandom, $urandom_range(0, 8),
                                    1'($urandom)));
                random_items += 2;
            end
            issue(make_item(ACT_START, $urandom, $urandom, $urandom, 1'($urandom)));
            ticks = 0;
            while (ticks < 80 && !(completed >= c && ticks > 3))
            begin
                if ($urandom_range(0, 14) == 0)
                    issue(noise_item());
                else
                    issue(make_item(ACT_TICK, $urandom, $urandom, $urandom, 1'($urandom)));
                ticks++;
                random_items++;
            end
        end

        @(negedge clk);
        start <= 1'b0;
        for (int i = 0; i < 20000 && due_results.size() != 0; i++)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (mismatches == 0 && due_results.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
